/* rtl/rria_pkg.sv */
package rria_pkg;

  localparam int RegCount = 16;
  localparam int IdxW = $clog2(RegCount);
  localparam int DataW = 64;
  localparam int CntW = $clog2(DataW + 1);

  localparam logic [2:0] REQ_PUSH    = 3'd0;
  localparam logic [2:0] REQ_RING    = 3'd1;
  localparam logic [2:0] REQ_IMM_CUR = 3'd2;
  localparam logic [2:0] REQ_CUR_IMM = 3'd3;
  localparam logic [2:0] REQ_IMM_IMM = 3'd4;
  localparam logic [2:0] REQ_ADVANCE = 3'd5;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_MOD = 4'd4;
  localparam logic [3:0] OP_SHL = 4'd5;
  localparam logic [3:0] OP_SHR = 4'd6;
  localparam logic [3:0] OP_AND = 4'd7;
  localparam logic [3:0] OP_OR  = 4'd8;
  localparam logic [3:0] OP_XOR = 4'd9;
  localparam logic [3:0] OP_POW = 4'd10;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_DIV0   = 2'd1;
  localparam logic [1:0] ERR_NEGEXP = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [3:0]  op;
    logic [63:0] first_value;
    logic [63:0] second_value;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic [3:0]  dest_index;
    logic        wrote;
    logic [1:0]  error_code;
    logic [3:0]  ring_position;
  } out_beat_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture request, read ring
    logic operands;  // select operands from ring read data
    logic simple;    // ops that need no iteration
    logic iter;      // one iteration of mul, div or pow
    logic fixup;     // sign fix of quotient, final value select
    logic commit;    // write ring, build result
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_compute;
    logic is_iter;
    logic iter_done;
  } dp_stat_t;

endpackage

/* rtl/ring_register_integer_alu.sv */
// Path from accept to result beat: push, advance and unused codes pass read and write only;
// non-iterating ops, div/mod by zero and pow with zero or negative exponent add the operand step;
// mul adds one multiply step, div and mod a 64-step divider, and pow 64 steps.
// Throughput: one statement at a time; next accepted the cycle after result taken.
// Reset (rst, synchronous, active high): pointer 0, ring reads as zero via
// per-slot valid bits, signed_mode 1, no result pending.
module ring_register_integer_alu
  import rria_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  logic     signed_mode;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) signed_mode <= 1'b1;
    else if (cfg_we) signed_mode <= cfg_wdata;
  end

  rria_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .stat, .cmd
  );

  rria_dp u_dp (
    .clk, .rst, .signed_mode, .in_beat(in_data), .cmd, .stat,
    .out_beat(out_data)
  );

endmodule

/* rtl/rria_ctrl.sv */
module rria_ctrl
  import rria_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_OPND  = 7'b0000100,
    S_ITER  = 7'b0001000,
    S_FIX   = 7'b0010000,
    S_WRITE = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state, state_next;

  // sequencing
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: state_next = stat.is_compute ? S_OPND : S_WRITE;
      S_OPND: begin
        cmd.operands = 1'b1;
        state_next = stat.is_iter ? S_ITER : S_WRITE;
        if (!stat.is_iter) cmd.simple = 1'b1;
      end
      S_ITER: begin
        cmd.iter = 1'b1;
        if (stat.iter_done) state_next = S_FIX;
      end
      S_FIX: begin
        cmd.fixup = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        cmd.commit = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_out_after_write: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("result shown without commit");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("accept while result pending");

endmodule

/* rtl/rria_dp.sv */
module rria_dp
  import rria_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      signed_mode,
  input  in_beat_t  in_beat,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output out_beat_t out_beat
);

  logic [63:0]     ring [RegCount];
  logic [RegCount-1:0] vld;
  logic [IdxW-1:0] cur;
  in_beat_t        req;
  logic [63:0]     rd_cur, rd_prev;
  logic [IdxW-1:0] dest, prev;
  logic [63:0]     s, acc, rem, bas, ex;
  logic [63:0]     pa, pb;
  logic [1:0]      ph;
  logic [CntW-1:0] cnt;
  logic            negq;
  logic [1:0]      err;
  logic [63:0]     val;

  assign dest = (cur == IdxW'(RegCount - 1)) ? '0 : cur + 1'b1;
  assign prev = (cur == '0) ? IdxW'(RegCount - 1) : cur - 1'b1;

  // ring read, registered; invalid entries read as zero
  always_ff @(posedge clk) begin
    rd_cur  <= ring[cur];
    rd_prev <= ring[prev];
    if (cmd.load) req <= in_beat;
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (cmd.commit && err == ERR_NONE && req.req_type <= REQ_IMM_IMM)
      vld[dest] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && err == ERR_NONE && req.req_type <= REQ_IMM_IMM)
      ring[dest] <= (req.req_type == REQ_PUSH) ? req.first_value : val;
  end

  logic vc, vp;
  logic [63:0] rc, rp;
  always_ff @(posedge clk) begin
    vc <= vld[cur];
    vp <= vld[prev];
  end
  assign rc = vc ? rd_cur : '0;
  assign rp = vp ? rd_prev : '0;

  assign stat.is_compute = (req.req_type >= REQ_RING) && (req.req_type <= REQ_IMM_IMM);

  // operand select
  logic [63:0] fo, so;
  always_comb begin
    case (req.req_type)
      REQ_RING:    begin fo = rp; so = rc; end
      REQ_IMM_CUR: begin fo = req.first_value; so = rc; end
      REQ_CUR_IMM: begin fo = rc; so = req.first_value; end
      default:     begin fo = req.first_value; so = req.second_value; end
    endcase
  end

  wire div_like = (req.op == OP_DIV) || (req.op == OP_MOD);
  assign stat.is_iter = (req.op == OP_MUL) ||
                        ((div_like || req.op == OP_POW) && so != '0
                         && !(req.op == OP_POW && signed_mode && so[63]));
  assign stat.iter_done = (cnt == CntW'(1)) && (div_like || ph == 2'd2);

  // results that need no iteration
  logic [63:0] simple_v;
  logic [63:0] sh_r;
  always_comb begin
    sh_r = (so >= 64) ? ((signed_mode && fo[63]) ? '1 : '0)
         : ((signed_mode && fo[63]) ? ~((~fo) >> so[5:0]) : fo >> so[5:0]);
    case (req.op)
      OP_SUB: simple_v = fo - so;
      OP_SHL: simple_v = (so >= 64) ? '0 : fo << so[5:0];
      OP_SHR: simple_v = sh_r;
      OP_AND: simple_v = fo & so;
      OP_OR:  simple_v = fo | so;
      OP_XOR: simple_v = fo ^ so;
      OP_POW: simple_v = 64'd1;
      default: simple_v = fo + so;
    endcase
  end

  // restoring divider step
  logic [64:0] trial;
  assign trial = {rem[63:0], acc[63]} - {1'b0, s};

  // 32x32 partial products, low 64 bits built over three phases:
  // lo*lo, then lo*hi, then hi*lo shifted up by 32
  logic [31:0] ma_x, ma_y, mb_x, mb_y;
  logic [63:0] ma, mb;
  assign ma_x = (ph == 2'd2) ? acc[63:32] : acc[31:0];
  assign ma_y = (ph == 2'd1) ? bas[63:32] : bas[31:0];
  assign mb_x = (ph == 2'd2) ? bas[63:32] : bas[31:0];
  assign mb_y = (ph == 2'd1) ? bas[63:32] : bas[31:0];
  assign ma = 64'(ma_x) * 64'(ma_y);
  assign mb = 64'(mb_x) * 64'(mb_y);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err <= ERR_NONE;
    end else if (cmd.operands) begin
      negq <= signed_mode && req.op == OP_DIV && (fo[63] ^ so[63]);
      cnt <= (req.op == OP_MUL) ? CntW'(1) : CntW'(DataW);
      ph <= 2'd0;
      if (div_like && so == '0) err <= ERR_DIV0;
      else if (req.op == OP_POW && signed_mode && so[63]) err <= ERR_NEGEXP;
      val <= simple_v;
      if (div_like) begin
        rem <= '0;
        acc <= (signed_mode && req.op == OP_DIV && fo[63]) ? -fo : fo;
        s   <= (signed_mode && req.op == OP_DIV && so[63]) ? -so : so;
      end else if (req.op == OP_MUL) begin
        // one multiply step with exponent bit set
        acc <= fo;
        bas <= so;
        ex  <= 64'd1;
      end else begin
        acc <= 64'd1;
        bas <= fo;
        ex  <= so;
      end
    end else if (cmd.iter) begin
      if (div_like) begin
        cnt <= cnt - 1'b1;
        if (!trial[64]) begin
          rem <= trial[63:0];
          acc <= {acc[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], acc[63]};
          acc <= {acc[62:0], 1'b0};
        end
      end else begin
        case (ph)
          2'd0: begin
            pa <= ma;
            pb <= mb;
            ph <= 2'd1;
          end
          2'd1: begin
            pa <= pa + {ma[31:0], 32'b0};
            pb <= pb + {mb[31:0], 32'b0};
            ph <= 2'd2;
          end
          default: begin
            if (ex[0]) acc <= pa + {ma[31:0], 32'b0};
            bas <= pb + {mb[31:0], 32'b0};
            ex  <= ex >> 1;
            cnt <= cnt - 1'b1;
            ph  <= 2'd0;
          end
        endcase
      end
    end else if (cmd.fixup) begin
      if (req.op == OP_MOD) val <= rem;
      else if (req.op == OP_DIV) val <= negq ? -acc : acc;
      else val <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) cur <= '0;
    else if (cmd.commit) begin
      if (req.req_type == REQ_ADVANCE ||
          (err == ERR_NONE && req.req_type <= REQ_IMM_IMM)) cur <= dest;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_beat.dest_index <= 4'(dest);
      out_beat.error_code <= stat.is_compute ? err : ERR_NONE;
      out_beat.wrote <= (req.req_type == REQ_PUSH) ||
                        (stat.is_compute && err == ERR_NONE);
      out_beat.result_value <= (req.req_type == REQ_PUSH) ? req.first_value :
                               (stat.is_compute && err == ERR_NONE) ? val : '0;
      out_beat.ring_position <= 4'((req.req_type == REQ_ADVANCE ||
          (err == ERR_NONE && req.req_type <= REQ_IMM_IMM)) ? dest : cur);
    end
  end

  a_err_no_iter: assert property (@(posedge clk) disable iff (rst)
    cmd.iter |-> err == ERR_NONE)
    else $error("iterating on error");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cmd.iter |-> cnt != '0)
    else $error("iteration count underflow");
  a_ptr_step: assert property (@(posedge clk) disable iff (rst)
    !$past(cmd.commit) && !$past(rst) |-> $stable(cur))
    else $error("pointer moved outside commit");

endmodule

/* test/tb.sv */
module tb;
  import rria_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Codes that the package leaves unnamed
  localparam logic [2:0] REQ_SPARE6 = 3'd6;
  localparam logic [2:0] REQ_SPARE7 = 3'd7;
  localparam logic [3:0] OP_SPARE11 = 4'd11;
  localparam logic [3:0] OP_SPARE15 = 4'd15;

  localparam logic [63:0] MIN_S64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAX_S64 = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] ALL_ONES = '1;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;

  ring_register_integer_alu DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Shadow copy of the ring, the pointer and the mode
  logic [63:0] ring_shadow [RegCount];
  logic [3:0]  slot_shadow;
  logic        signed_shadow;

  out_beat_t result_q [$];
  int  stmts_sent = 0;
  int  results_seen = 0;
  int  mismatches = 0;
  int  err_results = 0;
  bit  calm = 1'b0;
  bit  hold_go = 1'b0;

  function automatic logic [63:0] alu_result(logic [3:0] op, logic [63:0] f, logic [63:0] s,
                                             output logic [1:0] err);
    logic [63:0] mf, ms, q, acc, b, e;
    err = ERR_NONE;
    case (op)
      OP_SUB: return f - s;
      OP_MUL: return f * s;
      OP_DIV: begin
        if (s == 0) begin
          err = ERR_DIV0;
          return '0;
        end
        if (!signed_shadow) return f / s;
        mf = f[63] ? -f : f;
        ms = s[63] ? -s : s;
        q = mf / ms;
        return (f[63] != s[63]) ? -q : q;
      end
      OP_MOD: begin
        if (s == 0) begin
          err = ERR_DIV0;
          return '0;
        end
        return f % s;
      end
      OP_SHL: return (s >= 64) ? '0 : f << s[5:0];
      OP_SHR: begin
        if (signed_shadow && f[63]) return (s >= 64) ? ALL_ONES : ~((~f) >> s[5:0]);
        return (s >= 64) ? '0 : f >> s[5:0];
      end
      OP_AND: return f & s;
      OP_OR:  return f | s;
      OP_XOR: return f ^ s;
      OP_POW: begin
        if (signed_shadow && s[63]) begin
          err = ERR_NEGEXP;
          return '0;
        end
        acc = 1;
        b = f;
        e = s;
        while (e != 0) begin
          if (e[0]) acc = acc * b;
          b = b * b;
          e = e >> 1;
        end
        return acc;
      end
      default: return f + s;
    endcase
  endfunction

  // Expected result of one statement; advances the shadow state
  function automatic out_beat_t run_statement(in_beat_t stmt);
    out_beat_t res;
    logic [3:0] cur, dest, prev;
    logic [63:0] f, s;
    logic [1:0] err;
    logic write;
    cur = slot_shadow;
    dest = cur + 4'd1;
    prev = cur - 4'd1;
    f = '0;
    s = '0;
    err = ERR_NONE;
    write = 1'b0;
    res = '0;
    case (stmt.req_type)
      REQ_PUSH: begin
        res.result_value = stmt.first_value;
        write = 1'b1;
      end
      REQ_RING: begin
        f = ring_shadow[prev];
        s = ring_shadow[cur];
      end
      REQ_IMM_CUR: begin
        f = stmt.first_value;
        s = ring_shadow[cur];
      end
      REQ_CUR_IMM: begin
        f = ring_shadow[cur];
        s = stmt.first_value;
      end
      REQ_IMM_IMM: begin
        f = stmt.first_value;
        s = stmt.second_value;
      end
      REQ_ADVANCE: slot_shadow = dest;
      default: ;
    endcase
    if (stmt.req_type inside {REQ_RING, REQ_IMM_CUR, REQ_CUR_IMM, REQ_IMM_IMM}) begin
      res.result_value = alu_result(stmt.op, f, s, err);
      write = (err == ERR_NONE);
    end
    if (write) begin
      ring_shadow[dest] = res.result_value;
      slot_shadow = dest;
    end
    res.dest_index = dest;
    res.wrote = write;
    res.error_code = err;
    res.ring_position = slot_shadow;
    return res;
  endfunction

  // Send one statement; valid is left high so a back-to-back beat needs no re-raise
  task automatic send_stmt(logic [2:0] req, logic [3:0] op, logic [63:0] a, logic [63:0] b);
    in_beat_t beat;
    beat = '{req_type: req, op: op, first_value: a, second_value: b};
    if (!calm && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (!in_ready);
    result_q.push_back(run_statement(beat));
    stmts_sent++;
  endtask

  // Stop offering and wait until every result is back and the block is idle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode(logic mode);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    signed_shadow = mode;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return 64'd1;
      2: return ALL_ONES;
      3: return MIN_S64;
      4: return MAX_S64;
      5, 6: return 64'($urandom_range(0, 70));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Mostly real computations, with some unused codes and advances mixed in
  task automatic send_random_stmt();
    logic [2:0] req;
    req = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    send_stmt(req, 4'($urandom_range(0, 15)), pick_value(), pick_value());
  endtask

  task automatic test_directed();
    send_stmt(REQ_PUSH, OP_ADD, ALL_ONES, '0);
    send_stmt(REQ_PUSH, OP_ADD, MIN_S64, ALL_ONES);
    send_stmt(REQ_RING, OP_ADD, '0, '0);
    send_stmt(REQ_RING, OP_SUB, '0, '0);
    send_stmt(REQ_IMM_CUR, OP_MUL, MAX_S64, '0);
    send_stmt(REQ_CUR_IMM, OP_DIV, '0, 64'd7);
    send_stmt(REQ_IMM_IMM, OP_DIV, MIN_S64, ALL_ONES);
    send_stmt(REQ_IMM_IMM, OP_DIV, 64'd5, '0);
    send_stmt(REQ_IMM_IMM, OP_MOD, 64'd5, '0);
    send_stmt(REQ_IMM_IMM, OP_MOD, ALL_ONES, 64'd10);
    send_stmt(REQ_IMM_IMM, OP_SHL, 64'd3, 64'd63);
    send_stmt(REQ_IMM_IMM, OP_SHL, 64'd3, 64'd64);
    send_stmt(REQ_IMM_IMM, OP_SHR, MIN_S64, 64'd4);
    send_stmt(REQ_IMM_IMM, OP_SHR, MIN_S64, ALL_ONES);
    send_stmt(REQ_IMM_IMM, OP_AND, ALL_ONES, MAX_S64);
    send_stmt(REQ_IMM_IMM, OP_OR, MIN_S64, 64'd1);
    send_stmt(REQ_IMM_IMM, OP_XOR, ALL_ONES, MAX_S64);
    send_stmt(REQ_IMM_IMM, OP_POW, 64'd3, 64'd40);
    send_stmt(REQ_IMM_IMM, OP_POW, 64'd2, ALL_ONES);
    send_stmt(REQ_IMM_IMM, OP_POW, ALL_ONES, '0);
    send_stmt(REQ_IMM_IMM, OP_SPARE11, 64'd9, 64'd1);
    send_stmt(REQ_IMM_IMM, OP_SPARE15, ALL_ONES, 64'd1);
    send_stmt(REQ_ADVANCE, OP_ADD, ALL_ONES, ALL_ONES);
    send_stmt(REQ_SPARE6, OP_ADD, 64'd1, 64'd1);
    send_stmt(REQ_SPARE7, OP_POW, ALL_ONES, ALL_ONES);
  endtask

  // Unsigned mode: same corner values, then random statements
  task automatic test_unsigned_mode();
    write_mode(1'b0);
    send_stmt(REQ_IMM_IMM, OP_DIV, MIN_S64, ALL_ONES);
    send_stmt(REQ_IMM_IMM, OP_SHR, MIN_S64, 64'd4);
    send_stmt(REQ_IMM_IMM, OP_SHR, MIN_S64, ALL_ONES);
    send_stmt(REQ_IMM_IMM, OP_POW, 64'd3, ALL_ONES);
    repeat (150) send_random_stmt();
    write_mode(1'b1);
  endtask

  task automatic test_random_traffic();
    repeat (300) send_random_stmt();
    calm = 1'b1;
    repeat (150) send_random_stmt();
    calm = 1'b0;
    write_mode(1'b0);
    repeat (150) send_random_stmt();
    write_mode(1'b1);
    repeat (150) send_random_stmt();
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_go = ~hold_go;
    repeat (20) send_random_stmt();
  endtask

  // Sender waits for every result before going on
  task automatic test_sender_pause();
    repeat (10) send_random_stmt();
    drain_results();
    repeat (40) send_random_stmt();
  endtask

  // Receiver: random stalls, calm stretches, and one long hold-off
  initial begin
    int hold_left;
    bit hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go != hold_seen) begin
        hold_seen = hold_go;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 7);
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (result_q.size() == 0) begin
        $error("result beat with nothing expected: %h", out_data);
        mismatches++;
      end else begin
        want = result_q.pop_front();
        if (out_data.error_code != ERR_NONE) err_results++;
        if (out_data.result_value !== want.result_value) begin
          $error("result_value exp %h got %h", want.result_value, out_data.result_value);
          mismatches++;
        end
        if (out_data.dest_index !== want.dest_index) begin
          $error("dest_index exp %0d got %0d", want.dest_index, out_data.dest_index);
          mismatches++;
        end
        if (out_data.wrote !== want.wrote) begin
          $error("wrote exp %0d got %0d", want.wrote, out_data.wrote);
          mismatches++;
        end
        if (out_data.error_code !== want.error_code) begin
          $error("error_code exp %0d got %0d", want.error_code, out_data.error_code);
          mismatches++;
        end
        if (out_data.ring_position !== want.ring_position) begin
          $error("ring_position exp %0d got %0d", want.ring_position, out_data.ring_position);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    int idle_cycles;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < RegCount; i++) ring_shadow[i] = '0;
    slot_shadow = '0;
    signed_shadow = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_unsigned_mode();
    test_random_traffic();
    test_backpressure();
    test_sender_pause();
    drain_results();
    repeat (80) @(posedge clk);
    $display("Covered %0d statements in both modes, %0d results checked, %0d error results.",
             stmts_sent, results_seen, err_results);
    $display("Included a long output hold-off and a sender pause until drained.");
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
